/* src/lfia_pkg.sv */
// shared types and codes for the lowest free id allocator
package lfia_pkg;

  // widest id the allocator supports (4096 ids)
  localparam int unsigned ID_MAX_W = 12;
  localparam int unsigned STATUS_W = 3;

  localparam logic OP_GET     = 1'b0;
  localparam logic OP_RECYCLE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ABOVE     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREE      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd4;

  // request travelling down the cell row
  typedef struct packed {
    logic                valid;
    logic                op;
    logic                above;
    logic [ID_MAX_W-1:0] id;
    logic                found;
    logic                was_free;
    logic [ID_MAX_W-1:0] hit_id;
  } token_t;

endpackage

/* src/lfia_cell.sv */
// one cell of the free map row: a slice of free bits and a token stage
module lfia_cell #(
  parameter int unsigned CellW   = 4,
  parameter int unsigned CellIdx = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lfia_pkg::token_t  tok_i,
  output lfia_pkg::token_t  tok_o
);

  localparam int unsigned CellBits = 2 ** CellW;

  logic [CellBits-1:0] bits_q, bits_d;
  lfia_pkg::token_t    tok_q, tok_d;
  logic [CellW-1:0]    low_idx;
  logic [CellW-1:0]    loc_idx;
  logic                hit;

  // lowest set bit of this slice
  always_comb begin
    low_idx = '0;
    for (int i = CellBits - 1; i >= 0; i--) begin
      if (bits_q[i]) begin
        low_idx = CellW'(i);
      end
    end
  end

  assign loc_idx = tok_i.id[CellW-1:0];
  assign hit     = (tok_i.id >> CellW) == lfia_pkg::ID_MAX_W'(CellIdx);

  always_comb begin
    bits_d = bits_q;
    tok_d  = tok_i;
    if (tok_i.valid) begin
      unique case (tok_i.op)
        lfia_pkg::OP_GET: begin
          if (!tok_i.found && (|bits_q)) begin
            bits_d[low_idx] = 1'b0;
            tok_d.found     = 1'b1;
            tok_d.hit_id    = (lfia_pkg::ID_MAX_W'(CellIdx) << CellW)
                              | lfia_pkg::ID_MAX_W'(low_idx);
          end
        end
        lfia_pkg::OP_RECYCLE: begin
          if (hit && !tok_i.above) begin
            if (bits_q[loc_idx]) begin
              tok_d.was_free = 1'b1;
            end else if (tok_i.id != '0) begin
              bits_d[loc_idx] = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
      tok_q  <= '0;
    end else begin
      bits_q <= bits_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

/* src/lowest_free_id_allocator.sv */
// lowest free id allocator: cell row holding the free map plus control
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o    op_i, release_id_i
//   out      output     out_valid_o / out_stall_i  granted_id_o, status_o, high_water_o
//
// an item walks the row of 2**(IdW-CellW) cells, one cell a cycle (8 cells for 128 ids);
// the result then goes from pend_q at the row end into the output registers, and a new item
// is taken only once the previous result has left pend_q for the output registers
// reset clears the high-water counter and every free bit at once, no sweep
// an unread result keeps the next item parked at the row end, in_stall_o high, until taken
module lowest_free_id_allocator #(
  parameter int unsigned ID_SPACE = 128
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 op_i,
  input  logic [$clog2(ID_SPACE)-1:0]          release_id_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [$clog2(ID_SPACE)-1:0]          granted_id_o,
  output logic [lfia_pkg::STATUS_W-1:0]        status_o,
  output logic [$clog2(ID_SPACE)-1:0]          high_water_o
);

  localparam int unsigned IdW      = $clog2(ID_SPACE);
  localparam int unsigned CellW    = (IdW < 4) ? IdW : 4;
  localparam int unsigned NumCells = 2 ** (IdW - CellW);
  localparam logic [IdW-1:0] IdLast = IdW'(ID_SPACE - 1);

  lfia_pkg::token_t chain [NumCells+1];
  lfia_pkg::token_t inj_q, inj_d;
  lfia_pkg::token_t pend_q, pend_d;

  logic                          busy_q, busy_d;
  logic [IdW-1:0]                issued_q, issued_d;
  logic                          out_valid_q, out_valid_d;
  logic [IdW-1:0]                granted_q, granted_d;
  logic [lfia_pkg::STATUS_W-1:0] status_q, status_d;
  logic                          accept;
  logic                          finish;
  logic [NumCells:0]             tok_vld;

  assign accept = in_valid_i && !busy_q;
  assign finish = pend_q.valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    inj_d          = '0;
    inj_d.valid    = accept;
    inj_d.op       = op_i;
    inj_d.id       = lfia_pkg::ID_MAX_W'(release_id_i);
    inj_d.above    = release_id_i > issued_q;
  end

  assign chain[0] = inj_q;

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    lfia_cell #(
      .CellW   (CellW),
      .CellIdx (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (chain[k]),
      .tok_o  (chain[k+1])
    );
  end

  // catch the token leaving the row; it waits here for the output slot
  always_comb begin
    pend_d = pend_q;
    if (chain[NumCells].valid) begin
      pend_d = chain[NumCells];
    end else if (finish) begin
      pend_d.valid = 1'b0;
    end
  end

  always_comb begin
    busy_d      = busy_q;
    issued_d    = issued_q;
    out_valid_d = out_valid_q && out_stall_i;
    granted_d   = granted_q;
    status_d    = status_q;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (finish) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
      granted_d   = '0;
      status_d    = lfia_pkg::ST_OK;
      if (pend_q.op == lfia_pkg::OP_GET) begin
        priority if (pend_q.found) begin
          granted_d = IdW'(pend_q.hit_id);
        end else if (issued_q >= IdLast) begin
          status_d = lfia_pkg::ST_EXHAUSTED;
        end else begin
          issued_d  = issued_q + 1'b1;
          granted_d = issued_q + 1'b1;
        end
      end else begin
        priority if (pend_q.above) begin
          status_d = lfia_pkg::ST_ABOVE;
        end else if (pend_q.was_free) begin
          status_d = lfia_pkg::ST_FREE;
        end else if (pend_q.id == '0) begin
          status_d = lfia_pkg::ST_ZERO;
        end else begin
          status_d = lfia_pkg::ST_OK;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      issued_q    <= '0;
      out_valid_q <= 1'b0;
      inj_q       <= '0;
      pend_q      <= '0;
    end else begin
      busy_q      <= busy_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
      inj_q       <= inj_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    granted_q <= granted_d;
    status_q  <= status_d;
  end

  assign in_stall_o   = busy_q;
  assign out_valid_o  = out_valid_q;
  assign granted_id_o = granted_q;
  assign status_o     = status_q;
  assign high_water_o = issued_q;

  always_comb begin
    for (int k = 0; k <= NumCells; k++) begin
      tok_vld[k] = chain[k].valid;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({tok_vld, pend_q.valid}))
    else $error("more than one item in flight");

  a_hw_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> issued_q >= $past(issued_q))
    else $error("high-water counter went down");

  a_exhausted_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == lfia_pkg::ST_EXHAUSTED |-> high_water_o == IdLast)
    else $error("exhausted reported below the top of the id space");

  a_grant_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> granted_id_o <= high_water_o)
    else $error("granted id above high-water mark");
`endif

endmodule

/* sim/lfia_checker.sv */
// checker for the lowest free id allocator: predicts each result and compares it
module lfia_checker #(
  parameter int unsigned ID_SPACE = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          op_i,
  input  logic [$clog2(ID_SPACE)-1:0]   release_id_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [$clog2(ID_SPACE)-1:0]   granted_id_i,
  input  logic [lfia_pkg::STATUS_W-1:0] status_i,
  input  logic [$clog2(ID_SPACE)-1:0]   high_water_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ID_W = $clog2(ID_SPACE);

  typedef struct packed {
    logic [ID_W-1:0]               granted_id;
    logic [lfia_pkg::STATUS_W-1:0] status;
    logic [ID_W-1:0]               high_water;
  } alloc_result_t;

  logic [ID_SPACE-1:0] free_ids;
  logic [ID_W-1:0]     issued_mark;
  alloc_result_t       pending_results[$];
  int                  fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_results.size();

  function automatic alloc_result_t predict_alloc(input logic op,
                                                  input logic [ID_W-1:0] rel_id);
    alloc_result_t res;
    logic          found;
    logic [ID_W-1:0] pick;
    res   = '0;
    found = 1'b0;
    pick  = '0;
    if (op == lfia_pkg::OP_GET) begin
      // lowest recycled id wins over a fresh one
      for (int i = 1; i < ID_SPACE; i++) begin
        if (!found && free_ids[i]) begin
          found = 1'b1;
          pick  = ID_W'(i);
        end
      end
      if (found) begin
        free_ids[pick] = 1'b0;
        res.granted_id = pick;
        res.status     = lfia_pkg::ST_OK;
      end else if (int'(issued_mark) >= ID_SPACE - 1) begin
        res.status = lfia_pkg::ST_EXHAUSTED;
      end else begin
        issued_mark           = issued_mark + 1'b1;
        free_ids[issued_mark] = 1'b0;
        res.granted_id        = issued_mark;
        res.status            = lfia_pkg::ST_OK;
      end
    end else begin
      if (rel_id > issued_mark) begin
        res.status = lfia_pkg::ST_ABOVE;
      end else if (free_ids[rel_id]) begin
        res.status = lfia_pkg::ST_FREE;
      end else if (rel_id == '0) begin
        res.status = lfia_pkg::ST_ZERO;
      end else begin
        free_ids[rel_id] = 1'b1;
        res.status       = lfia_pkg::ST_OK;
      end
    end
    res.high_water = issued_mark;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t want;
    if (!rst_ni) begin
      free_ids    = '0;
      issued_mark = '0;
      pending_results.delete();
      fail_count  = 0;
    end else begin
      // a result leaves only after its item has crossed the cell row, so compare before pushing
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("result with no item outstanding: granted_id %0d status %0d high_water %0d",
                 granted_id_i, status_i, high_water_i);
          fail_count = fail_count + 1;
        end else begin
          want = pending_results.pop_front();
          if (granted_id_i !== want.granted_id) begin
            $error("granted_id: expected %0d, actual %0d", want.granted_id, granted_id_i);
            fail_count = fail_count + 1;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_i);
            fail_count = fail_count + 1;
          end
          if (high_water_i !== want.high_water) begin
            $error("high_water: expected %0d, actual %0d", want.high_water, high_water_i);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pending_results.push_back(predict_alloc(op_i, release_id_i));
      end
    end
  end

endmodule

/* sim/tb.sv */
// top of the allocator testbench: clock, reset, item traffic and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ID_SPACE   = 128;
  localparam int unsigned ID_W       = $clog2(ID_SPACE);
  localparam int          IDLE_LIMIT = 2000;
  localparam int          HOLD_LEN   = 300;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_valid   = 1'b0;
  logic                          in_stall;
  logic                          op         = lfia_pkg::OP_GET;
  logic [ID_W-1:0]               release_id = '0;
  logic                          out_valid;
  logic                          out_stall  = 1'b0;
  logic [ID_W-1:0]               granted_id;
  logic [lfia_pkg::STATUS_W-1:0] status;
  logic [ID_W-1:0]               high_water;

  int fail_count;
  int pending;
  int send_idle_pct = 7;
  int recv_idle_pct = 58;
  int gets_sent     = 0;
  int idle_cycles   = 0;
  bit hold_req      = 1'b0;
  bit hold_done     = 1'b0;
  int hold_left     = 0;

  lowest_free_id_allocator #(.ID_SPACE(ID_SPACE)) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .op_i         (op),
    .release_id_i (release_id),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .granted_id_o (granted_id),
    .status_o     (status),
    .high_water_o (high_water)
  );

  lfia_checker #(.ID_SPACE(ID_SPACE)) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .op_i         (op),
    .release_id_i (release_id),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .granted_id_i (granted_id),
    .status_i     (status),
    .high_water_i (high_water),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // offers one item and returns at the falling edge after it is taken
  task automatic send_item(input logic item_op, input logic [ID_W-1:0] item_id);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    op         <= item_op;
    release_id <= item_id;
    if (item_op == lfia_pkg::OP_GET) gets_sent++;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // runs of gets, runs of plausible recycles, and some fully random items
  task automatic run_random(input int n_items);
    int sent;
    int kind;
    int run_len;
    int bound;
    sent = 0;
    while (sent < n_items) begin
      kind    = $urandom_range(9, 0);
      run_len = $urandom_range(8, 1);
      for (int k = 0; k < run_len && sent < n_items; k++) begin
        bound = (gets_sent < ID_SPACE - 1) ? gets_sent : ID_SPACE - 1;
        if (kind <= 3) begin
          send_item(lfia_pkg::OP_GET, ID_W'($urandom_range(ID_SPACE - 1, 0)));
        end else if (kind <= 7 && bound > 0) begin
          send_item(lfia_pkg::OP_RECYCLE, ID_W'($urandom_range(bound, 1)));
        end else begin
          send_item(1'($urandom_range(1, 0)), ID_W'($urandom_range(ID_SPACE - 1, 0)));
        end
        sent++;
      end
    end
  endtask

  // receiver: random stalls, plus one long hold-off so the input backs up
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done && hold_left == 0) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
        if (hold_left == 0) hold_done = 1'b1;
      end else begin
        out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("[lowest_free_id_allocator] ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // zero and above high-water on an empty allocator
    send_item(lfia_pkg::OP_RECYCLE, '0);
    send_item(lfia_pkg::OP_RECYCLE, ID_W'(ID_SPACE - 1));
    send_item(lfia_pkg::OP_GET, ID_W'(ID_SPACE - 1));
    send_item(lfia_pkg::OP_GET, '0);
    send_item(lfia_pkg::OP_GET, '0);
    send_item(lfia_pkg::OP_GET, '0);
    send_item(lfia_pkg::OP_RECYCLE, ID_W'(2));
    send_item(lfia_pkg::OP_RECYCLE, ID_W'(2));
    send_item(lfia_pkg::OP_RECYCLE, '0);
    send_item(lfia_pkg::OP_RECYCLE, ID_W'(5));
    send_item(lfia_pkg::OP_RECYCLE, ID_W'(4));
    send_item(lfia_pkg::OP_GET, '0);
    send_item(lfia_pkg::OP_GET, '0);
    send_item(lfia_pkg::OP_GET, '0);
    send_item(lfia_pkg::OP_RECYCLE, ID_W'(1));
    send_item(lfia_pkg::OP_RECYCLE, ID_W'(3));
    send_item(lfia_pkg::OP_GET, '0);
    send_item(lfia_pkg::OP_RECYCLE, ID_W'(ID_SPACE - 1));
    send_item(lfia_pkg::OP_GET, '0);
    send_item(lfia_pkg::OP_GET, '0);

    run_random(260);

    send_idle_pct = 58;
    recv_idle_pct = 7;
    // enough gets in a row to run the counter out and hit exhaustion
    repeat (140) send_item(lfia_pkg::OP_GET, ID_W'($urandom_range(ID_SPACE - 1, 0)));
    run_random(130);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(40);
    hold_req = 1'b1;
    run_random(230);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[lowest_free_id_allocator] OK");
    end else begin
      $display("[lowest_free_id_allocator] ERROR");
    end
    $finish;
  end

endmodule
